[hw/rtl/rthsv_pkg.sv]
// shared types and constants for the rgb to hsv pixel unit
// no dependencies; imported by every module of the block

package rthsv_pkg;

    localparam int CH_W     = 8;              // channel and result byte width
    localparam int QUOT_W   = 8;              // quotient bits, one per divider cell
    localparam int SREM_W   = 2 * CH_W;       // saturation dividend 255*delta
    localparam int HREM_W   = 17;             // hue numerator, below 360*256
    localparam int HDIV_W   = CH_W + 1;       // hue divisor 2*delta

    localparam logic [SREM_W-1:0] SAT_SCALE  = SREM_W'(255);
    localparam logic [HREM_W-1:0] HUE_STEP   = HREM_W'(60);
    localparam logic [HREM_W-1:0] HUE_GREEN  = HREM_W'(120);
    localparam logic [HREM_W-1:0] HUE_BLUE   = HREM_W'(240);
    localparam logic [HREM_W-1:0] HUE_CIRCLE = HREM_W'(360);
    localparam logic [CH_W-1:0]   HUE_MAX    = CH_W'(179);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] hue_half;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] value;
    } t_pix_out;

    // state carried from one divider cell to the next
    typedef struct packed {
        logic [SREM_W-1:0] rem_sat;
        logic [CH_W-1:0]   div_sat;
        logic [HREM_W-1:0] rem_hue;
        logic [HDIV_W-1:0] div_hue;
        logic [QUOT_W-1:0] q_sat;
        logic [QUOT_W-1:0] q_hue;
        logic [CH_W-1:0]   value;
        logic              sat_zero;
        logic              hue_zero;
    } t_cell_data;

endpackage

[hw/rtl/rthsv_front.sv]
// front stage: max, min, delta and hue numerator of one pixel, registered
// depends on rthsv_pkg

module rthsv_front import rthsv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_pix_in    i_pix,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;
    logic [CH_W-1:0]  maxv;
    logic [CH_W-1:0]  minv;
    logic [CH_W-1:0]  delta;
    logic             red_max;
    logic             green_max;
    logic signed [CH_W+1:0]   diff_gb;
    logic signed [HREM_W:0]   num_red;
    logic [HREM_W-1:0] delta_circle;
    logic [HREM_W-1:0] num;

    always_comb begin
        red_max   = (i_pix.red >= i_pix.green) && (i_pix.red >= i_pix.blue);
        green_max = !red_max && (i_pix.green >= i_pix.blue);
        if (red_max) begin
            maxv = i_pix.red;
        end else if (green_max) begin
            maxv = i_pix.green;
        end else begin
            maxv = i_pix.blue;
        end
        minv = i_pix.red;
        if (i_pix.green < minv) begin
            minv = i_pix.green;
        end
        if (i_pix.blue < minv) begin
            minv = i_pix.blue;
        end
        delta = maxv - minv;

        diff_gb      = signed'({2'b00, i_pix.green}) - signed'({2'b00, i_pix.blue});
        num_red      = (HREM_W+1)'(diff_gb) * signed'({1'b0, HUE_STEP});
        delta_circle = HREM_W'(delta) * HUE_CIRCLE;

        // only the red sector can go negative; wrap it once around the circle
        if (red_max) begin
            if (num_red[HREM_W]) begin
                num = HREM_W'(num_red + signed'({1'b0, delta_circle}));
            end else begin
                num = HREM_W'(num_red);
            end
        end else if (green_max) begin
            num = HREM_W'(delta) * HUE_GREEN + HREM_W'(i_pix.blue) * HUE_STEP
                - HREM_W'(i_pix.red) * HUE_STEP;
        end else begin
            num = HREM_W'(delta) * HUE_BLUE + HREM_W'(i_pix.red) * HUE_STEP
                - HREM_W'(i_pix.green) * HUE_STEP;
        end

        n_data.rem_sat  = SREM_W'(delta) * SAT_SCALE;
        n_data.div_sat  = maxv;
        n_data.rem_hue  = num;
        n_data.div_hue  = {delta, 1'b0};
        n_data.q_sat    = '0;
        n_data.q_hue    = '0;
        n_data.value    = maxv;
        n_data.sat_zero = (maxv == '0);
        n_data.hue_zero = (delta == '0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/rthsv_div_cell.sv]
// one cell of the divider chain: retires quotient bit BIT_IDX of both divisions
// depends on rthsv_pkg

module rthsv_div_cell import rthsv_pkg::*; #(
    parameter int BIT_IDX = QUOT_W - 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell_data i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic              r_valid;
    t_cell_data        r_data;
    t_cell_data        n_data;
    logic [SREM_W-1:0] sat_trial;
    logic [HREM_W-1:0] hue_trial;
    logic              sat_ge;
    logic              hue_ge;

    always_comb begin
        sat_trial = SREM_W'(i_data.div_sat) << BIT_IDX;
        hue_trial = HREM_W'(i_data.div_hue) << BIT_IDX;
        sat_ge    = i_data.rem_sat >= sat_trial;
        hue_ge    = i_data.rem_hue >= hue_trial;

        n_data = i_data;
        if (sat_ge) begin
            n_data.rem_sat = i_data.rem_sat - sat_trial;
        end
        if (hue_ge) begin
            n_data.rem_hue = i_data.rem_hue - hue_trial;
        end
        n_data.q_sat[BIT_IDX] = sat_ge;
        n_data.q_hue[BIT_IDX] = hue_ge;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // partial remainders stay below the divisor shifted by this cell's bit index
    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_data.sat_zero |->
        r_data.rem_sat < (SREM_W'(r_data.div_sat) << BIT_IDX))
        else $error("saturation remainder out of range");

    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_data.hue_zero |->
        r_data.rem_hue < (HREM_W'(r_data.div_hue) << BIT_IDX))
        else $error("hue remainder out of range");

endmodule

[hw/rtl/rgb_to_hsv_pixel_unit.sv]
// top level of the rgb to hsv pixel converter: front stage and divider chain
// depends on rthsv_pkg, rthsv_front and rthsv_div_cell

// Converts one 8-bit RGB pixel to 8-bit HSV (hue in degrees halved, 0..179;
// saturation floor(255*delta/value); value = largest channel) per transaction.
// A new pixel is taken every clock unless a held-off output has filled the chain;
// each result is registered in the front stage and then in every divider cell: one
// stage finds max, min and the hue numerator, then a chain of eight divider cells
// retires one quotient bit of the saturation and hue divisions per cell. Each
// stage stalls on its own, so gaps in the stream are squeezed out when the output
// side holds off.

module rgb_to_hsv_pixel_unit import rthsv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pix_in  i_pix,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pix_out o_pix
);

    localparam int STAGES = QUOT_W + 1;
    localparam int OCC_W  = $clog2(STAGES + 1);

    logic       c_valid [0:QUOT_W];
    logic       c_ready [0:QUOT_W];
    t_cell_data c_data  [0:QUOT_W];

    rthsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_data  (c_data[0])
    );

    for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
        rthsv_div_cell #(
            .BIT_IDX (QUOT_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    assign c_ready[QUOT_W] = i_ready;
    assign o_valid         = c_valid[QUOT_W];

    always_comb begin
        o_pix.hue_half   = c_data[QUOT_W].hue_zero ? '0 : c_data[QUOT_W].q_hue;
        o_pix.saturation = c_data[QUOT_W].sat_zero ? '0 : c_data[QUOT_W].q_sat;
        o_pix.value      = c_data[QUOT_W].value;
    end

    // transactions in flight, for checking only
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    always_comb begin
        n_occ = r_occ;
        if (i_valid && o_ready && !(o_valid && i_ready)) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (!(i_valid && o_ready) && o_valid && i_ready) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(STAGES))
        else $error("more transactions in flight than stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == '0 |-> !o_valid)
        else $error("result without an accepted pixel");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == OCC_W'(STAGES) && !i_ready |-> !o_ready)
        else $error("pixel accepted into a full chain");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pix.hue_half <= HUE_MAX)
        else $error("hue out of range");

endmodule
